// File: rtl/core/sct_pkg.sv
// Shared types and constants for the shell command tokenizer core.
// Standalone package; used by the core, its two port checkers and the testbench.
package sct_pkg;

    localparam int CHAR_W     = 7;
    localparam int KIND_W     = 4;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;
    localparam int MAX_RES    = 3;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_WORD    = 4'd0;
    localparam logic [KIND_W-1:0] KIND_SQUOTE  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_DQUOTE  = 4'd2;
    localparam logic [KIND_W-1:0] KIND_PIPE    = 4'd3;
    localparam logic [KIND_W-1:0] KIND_IN      = 4'd4;
    localparam logic [KIND_W-1:0] KIND_OUT     = 4'd5;
    localparam logic [KIND_W-1:0] KIND_OPEN    = 4'd6;
    localparam logic [KIND_W-1:0] KIND_CLOSE   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_HEREDOC = 4'd8;
    localparam logic [KIND_W-1:0] KIND_APPEND  = 4'd9;
    localparam logic [KIND_W-1:0] KIND_AND     = 4'd10;
    localparam logic [KIND_W-1:0] KIND_OR      = 4'd11;

    // characters with a lexical meaning
    localparam logic [CHAR_W-1:0] CH_SPACE  = 7'd32;
    localparam logic [CHAR_W-1:0] CH_PIPE   = 7'h7C;
    localparam logic [CHAR_W-1:0] CH_AMP    = 7'h26;
    localparam logic [CHAR_W-1:0] CH_LT     = 7'h3C;
    localparam logic [CHAR_W-1:0] CH_GT     = 7'h3E;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 7'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 7'h29;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 7'h27;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 7'h22;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] chr;
        logic              chr_v;
        logic              first;
        logic              last;
        logic              done;
    } t_res;

endpackage

// File: rtl/core/shell_command_tokenizer_core.sv
// Shell command tokenizer core: splits a character stream into token words.
// Depends on sct_pkg for token kinds, character codes and the result type.
// An accepted input word passes the input register, then the result bundle
//   register, before its first result word shows on the output port.
// Throughput: one input word per cycle while each word makes at most one
//   result and the receiver keeps tready high; a word that makes more results
//   holds the output port while the three-slot result bundle drains one slot per cycle that m_axis_tready is high.
// Reset: synchronous, active low; clears the lexer state, empties both
//   registers and holds s_axis_tready low until the cycle after release.
module shell_command_tokenizer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // character[6:0], zero pad[7]
    input  logic [sct_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tlast,   // line_end
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // token_byte[6:0], byte_valid[7], token_first[8], token_last[9], zero pad
    output logic [sct_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic [sct_pkg::KIND_W-1:0]    m_axis_tuser,   // token_kind[3:0]
    output logic                          m_axis_tlast,   // line_done
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready
);
    import sct_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_QUOTED,
        MODE_WORD_AMP      // word whose held char is followed by a pending '&'
    } t_mode;

    typedef struct packed {
        t_mode             mode;
        logic              quote;    // 0 single, 1 double
        logic [CHAR_W-1:0] held;     // lookahead character
        logic              held_v;
        logic              started;  // current token already gave its first word
    } t_lex;

    typedef struct packed {
        t_lex           st;
        logic [1:0]     cnt;
        t_res [MAX_RES-1:0] res;
    } t_work;

    localparam t_lex LEX_RESET = '{MODE_IDLE, 1'b0, '0, 1'b0, 1'b0};

    // ---------------------------------------------------------------
    // Lexer step: each helper takes the work record and returns it updated
    // ---------------------------------------------------------------
    function automatic t_work emit(t_work w, logic [KIND_W-1:0] kind,
                                   logic [CHAR_W-1:0] b, logic v, logic f, logic l);
        t_work o;
        o = w;
        // drop anything past the third result
        if (w.cnt != 2'd3) begin
            o.res[w.cnt] = '{kind, b, v, f, l, 1'b0};
            o.cnt        = w.cnt + 2'd1;
        end
        return o;
    endfunction

    function automatic t_work emit_char(t_work w, logic [KIND_W-1:0] kind,
                                        logic [CHAR_W-1:0] ch, logic l);
        t_work o;
        o = emit(w, kind, ch, 1'b1, !w.st.started, l);
        o.st.started = 1'b1;
        return o;
    endfunction

    function automatic logic ends_word(logic [CHAR_W-1:0] c);
        return (c <= CH_SPACE) || (c == CH_PIPE) || (c == CH_LT) || (c == CH_GT) ||
               (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_SQUOTE) ||
               (c == CH_DQUOTE);
    endfunction

    function automatic logic [KIND_W-1:0] single_kind(logic [CHAR_W-1:0] c);
        logic [KIND_W-1:0] k;
        if (c == CH_PIPE)    k = KIND_PIPE;
        else if (c == CH_LT) k = KIND_IN;
        else                 k = KIND_OUT;
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] pair_kind(logic [CHAR_W-1:0] c);
        logic [KIND_W-1:0] k;
        if (c == CH_PIPE)    k = KIND_OR;
        else if (c == CH_LT) k = KIND_HEREDOC;
        else if (c == CH_GT) k = KIND_APPEND;
        else                 k = KIND_AND;
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] quote_kind(logic q);
        return q ? KIND_DQUOTE : KIND_SQUOTE;
    endfunction

    // nothing held and no token open
    function automatic t_work start_idle(t_work w, logic [CHAR_W-1:0] c);
        t_work o;
        o    = w;
        o.st = LEX_RESET;
        if (c <= CH_SPACE) begin
            o.st = LEX_RESET;
        end else if (c == CH_LPAREN || c == CH_RPAREN) begin
            o = emit(o, (c == CH_LPAREN) ? KIND_OPEN : KIND_CLOSE, c, 1'b1, 1'b1, 1'b1);
        end else if (c == CH_PIPE || c == CH_LT || c == CH_GT || c == CH_AMP) begin
            o.st.held   = c;
            o.st.held_v = 1'b1;
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            o.st.mode  = MODE_QUOTED;
            o.st.quote = (c == CH_DQUOTE);
        end else begin
            o.st.mode   = MODE_WORD;
            o.st.held   = c;
            o.st.held_v = 1'b1;
        end
        return o;
    endfunction

    function automatic t_work word_step(t_work w, logic [CHAR_W-1:0] c);
        t_work o;
        o = w;
        if (ends_word(c)) begin
            o = emit_char(o, KIND_WORD, w.st.held, 1'b1);
            o = start_idle(o, c);
        end else if (c == CH_AMP) begin
            o.st.mode = MODE_WORD_AMP;
        end else begin
            o = emit_char(o, KIND_WORD, w.st.held, 1'b0);
            o.st.held = c;
        end
        return o;
    endfunction

    function automatic t_work consume(t_work w, logic [CHAR_W-1:0] c);
        t_work             o;
        logic [CHAR_W-1:0] h;
        logic [CHAR_W-1:0] qc;
        o  = w;
        h  = w.st.held;
        qc = w.st.quote ? CH_DQUOTE : CH_SQUOTE;
        case (w.st.mode)
            MODE_IDLE: begin
                if (!w.st.held_v) begin
                    o = start_idle(o, c);
                end else if (c == h) begin
                    o    = emit(o, pair_kind(h), h, 1'b1, 1'b1, 1'b0);
                    o    = emit(o, pair_kind(h), c, 1'b1, 1'b0, 1'b1);
                    o.st = LEX_RESET;
                end else if (h == CH_AMP) begin
                    // lone '&' opens a word
                    o.st.mode    = MODE_WORD;
                    o.st.started = 1'b0;
                    o = word_step(o, c);
                end else begin
                    o = emit(o, single_kind(h), h, 1'b1, 1'b1, 1'b1);
                    o = start_idle(o, c);
                end
            end
            MODE_WORD: begin
                o = word_step(o, c);
            end
            MODE_QUOTED: begin
                if (c == qc) begin
                    if (w.st.held_v)
                        o = emit_char(o, quote_kind(w.st.quote), h, 1'b1);
                    else if (!w.st.started)
                        o = emit(o, quote_kind(w.st.quote), '0, 1'b0, 1'b1, 1'b1);
                    o.st = LEX_RESET;
                end else begin
                    if (w.st.held_v)
                        o = emit_char(o, quote_kind(w.st.quote), h, 1'b0);
                    o.st.held   = c;
                    o.st.held_v = 1'b1;
                end
            end
            default: begin
                if (c == CH_AMP) begin
                    o    = emit_char(o, KIND_WORD, h, 1'b1);
                    o    = emit(o, KIND_AND, CH_AMP, 1'b1, 1'b1, 1'b0);
                    o    = emit(o, KIND_AND, CH_AMP, 1'b1, 1'b0, 1'b1);
                    o.st = LEX_RESET;
                end else begin
                    // the pending '&' becomes part of the word
                    o         = emit_char(o, KIND_WORD, h, 1'b0);
                    o.st.mode = MODE_WORD;
                    o.st.held = CH_AMP;
                    o = word_step(o, c);
                end
            end
        endcase
        return o;
    endfunction

    function automatic t_work flush_line(t_work w);
        t_work             o;
        logic [CHAR_W-1:0] h;
        o = w;
        h = w.st.held;
        case (w.st.mode)
            MODE_IDLE: begin
                if (w.st.held_v) begin
                    if (h == CH_AMP)
                        o = emit(o, KIND_WORD, h, 1'b1, 1'b1, 1'b1);
                    else
                        o = emit(o, single_kind(h), h, 1'b1, 1'b1, 1'b1);
                end
            end
            MODE_WORD: begin
                o = emit_char(o, KIND_WORD, h, 1'b1);
            end
            MODE_QUOTED: begin
                if (w.st.held_v)
                    o = emit_char(o, quote_kind(w.st.quote), h, 1'b1);
                else if (!w.st.started)
                    o = emit(o, quote_kind(w.st.quote), '0, 1'b0, 1'b1, 1'b1);
            end
            default: begin
                o = emit_char(o, KIND_WORD, h, 1'b0);
                o = emit_char(o, KIND_WORD, CH_AMP, 1'b1);
            end
        endcase
        o.st = LEX_RESET;
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    logic              r_run;       // high from the cycle after reset release
    logic              r_in_v;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_end;
    t_lex              r_lex;
    logic              r_b_v;       // result bundle holds words to send
    logic [1:0]        r_b_cnt;
    logic [1:0]        r_b_idx;
    t_res [MAX_RES-1:0] r_b_res;

    t_work n_work;
    logic  in_fire;
    logic  out_fire;
    logic  b_last;
    logic  b_free;
    logic  advance;
    t_res  cur;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign b_last   = (r_b_idx == (r_b_cnt - 2'd1));
    // the bundle can take a new load when empty or its final word leaves now
    assign b_free   = !r_b_v || (out_fire && b_last);
    assign advance  = r_in_v && b_free;

    // accept while the input register is empty or moves on this cycle
    assign s_axis_tready = r_run && (!r_in_v || b_free);

    // run one lexer step on the registered word, then close the line if flagged
    always_comb begin
        n_work     = '0;
        n_work.st  = r_lex;
        n_work     = consume(n_work, r_in_char);
        if (r_in_end) begin
            n_work = flush_line(n_work);
            // a line end always gives at least a marker word
            if (n_work.cnt == 2'd0)
                n_work = emit(n_work, KIND_WORD, '0, 1'b0, 1'b0, 1'b0);
            n_work.res[n_work.cnt - 2'd1].done = 1'b1;
        end
    end

    // control: input valid, lexer state, bundle occupancy and read slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_in_v  <= 1'b0;
            r_lex   <= LEX_RESET;
            r_b_v   <= 1'b0;
            r_b_cnt <= 2'd0;
            r_b_idx <= 2'd0;
        end else begin
            r_run <= 1'b1;
            if (in_fire)
                r_in_v <= 1'b1;
            else if (advance)
                r_in_v <= 1'b0;

            if (advance)
                r_lex <= n_work.st;

            // load a fresh bundle, else step through the one on show
            if (advance && (n_work.cnt != 2'd0)) begin
                r_b_v   <= 1'b1;
                r_b_cnt <= n_work.cnt;
                r_b_idx <= 2'd0;
            end else if (out_fire) begin
                if (b_last)
                    r_b_v <= 1'b0;
                else
                    r_b_idx <= r_b_idx + 2'd1;
            end
        end
    end

    // payload: held character and result words
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_char <= s_axis_tdata[CHAR_W-1:0];
            r_in_end  <= s_axis_tlast;
        end
        if (advance && (n_work.cnt != 2'd0))
            r_b_res <= n_work.res;
    end

    // ---------------------------------------------------------------
    // Output word
    // ---------------------------------------------------------------
    assign cur           = r_b_res[r_b_idx];
    assign m_axis_tvalid = r_b_v;
    assign m_axis_tdata  = {{(M_TDATA_W-CHAR_W-3){1'b0}},
                            cur.last, cur.first, cur.chr_v, cur.chr};
    assign m_axis_tuser  = cur.kind;
    assign m_axis_tlast  = cur.done;

endmodule

// File: rtl/core/sct_checker.sv
// Port-level checker for the shell command tokenizer core, with its bind.
// Depends on sct_pkg for widths and token kinds.
module sct_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tready,
    input logic [sct_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [sct_pkg::KIND_W-1:0]    m_axis_tuser,
    input logic                          m_axis_tlast,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready
);
    import sct_pkg::*;

    logic w_valid;
    logic w_first;
    logic w_last;

    assign w_valid = m_axis_tdata[CHAR_W];
    assign w_first = m_axis_tdata[CHAR_W+1];
    assign w_last  = m_axis_tdata[CHAR_W+2];

    // hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid &&
        $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // a word without a character is an empty quoted token or the line marker
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !w_valid |->
        (w_first && w_last && (m_axis_tuser == KIND_SQUOTE || m_axis_tuser == KIND_DQUOTE)) ||
        (m_axis_tlast && !w_first && !w_last && m_axis_tuser == KIND_WORD))
        else $error("empty word of wrong shape");

    // single operators and parentheses are one-word tokens
    a_single_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser >= KIND_PIPE && m_axis_tuser <= KIND_CLOSE |->
        w_valid && w_first && w_last)
        else $error("single operator spans more than one word");

    // nothing is offered or taken right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("handshake active after reset");

endmodule

bind shell_command_tokenizer_core sct_checker u_sct_checker (.*);

// File: dv/sct_token_checker.sv
// Port checker for the shell command tokenizer core: predicts token words.
// Watches both stream ports; depends on sct_pkg for kinds, characters and t_res.
module sct_token_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [sct_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                          i_s_tlast,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [sct_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  logic [sct_pkg::KIND_W-1:0]    i_m_tuser,
    input  logic                          i_m_tlast,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    output int                            o_pending,
    output int                            o_fail_cnt
);
    import sct_pkg::*;

    typedef enum logic [1:0] {
        LEX_IDLE,
        LEX_WORD,
        LEX_QUOTED,
        LEX_WORD_AMP    // held word char, then an '&' not yet decided
    } t_lex_mode;

    t_lex_mode         lex_mode;
    logic              in_dquote;
    logic [CHAR_W-1:0] held_chr;
    logic              held_v;
    logic              tok_open;

    t_res step_q[$];    // token words caused by the current character
    t_res tok_q[$];     // token words still to come out of the core
    t_res want_res;
    t_res got_res;
    int   fail_cnt = 0;
    int   word_idx = 0;

    task automatic clear_lex();
        lex_mode  = LEX_IDLE;
        in_dquote = 1'b0;
        held_chr  = '0;
        held_v    = 1'b0;
        tok_open  = 1'b0;
    endtask

    task automatic put_res(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] chr,
                           input logic chr_v, input logic first, input logic last);
        t_res r;
        if (step_q.size() < MAX_RES) begin
            r.kind  = kind;
            r.chr   = chr;
            r.chr_v = chr_v;
            r.first = first;
            r.last  = last;
            r.done  = 1'b0;
            step_q.push_back(r);
        end
    endtask

    task automatic put_tok_char(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] chr,
                                input logic last);
        put_res(kind, chr, 1'b1, !tok_open, last);
        tok_open = 1'b1;
    endtask

    function automatic logic breaks_word(input logic [CHAR_W-1:0] c);
        return c <= CH_SPACE || c == CH_PIPE || c == CH_LT || c == CH_GT ||
               c == CH_LPAREN || c == CH_RPAREN || c == CH_SQUOTE || c == CH_DQUOTE;
    endfunction

    function automatic logic [KIND_W-1:0] op_kind(input logic [CHAR_W-1:0] c);
        if (c == CH_PIPE) return KIND_PIPE;
        if (c == CH_LT) return KIND_IN;
        return KIND_OUT;
    endfunction

    function automatic logic [KIND_W-1:0] pair_kind(input logic [CHAR_W-1:0] c);
        if (c == CH_PIPE) return KIND_OR;
        if (c == CH_LT) return KIND_HEREDOC;
        if (c == CH_GT) return KIND_APPEND;
        return KIND_AND;
    endfunction

    function automatic logic [KIND_W-1:0] quote_kind();
        return in_dquote ? KIND_DQUOTE : KIND_SQUOTE;
    endfunction

    // Open whatever token c starts, with nothing held.
    task automatic begin_token(input logic [CHAR_W-1:0] c);
        clear_lex();
        if (c <= CH_SPACE)
            return;
        if (c == CH_LPAREN || c == CH_RPAREN) begin
            put_res(c == CH_LPAREN ? KIND_OPEN : KIND_CLOSE, c, 1'b1, 1'b1, 1'b1);
        end else if (c == CH_PIPE || c == CH_LT || c == CH_GT || c == CH_AMP) begin
            held_chr = c;
            held_v   = 1'b1;
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            lex_mode  = LEX_QUOTED;
            in_dquote = (c == CH_DQUOTE);
        end else begin
            lex_mode = LEX_WORD;
            held_chr = c;
            held_v   = 1'b1;
        end
    endtask

    task automatic word_advance(input logic [CHAR_W-1:0] c);
        if (breaks_word(c)) begin
            put_tok_char(KIND_WORD, held_chr, 1'b1);
            begin_token(c);
        end else if (c == CH_AMP) begin
            lex_mode = LEX_WORD_AMP;
        end else begin
            put_tok_char(KIND_WORD, held_chr, 1'b0);
            held_chr = c;
        end
    endtask

    task automatic take_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] h;
        logic [CHAR_W-1:0] closing;
        h       = held_chr;
        closing = in_dquote ? CH_DQUOTE : CH_SQUOTE;
        case (lex_mode)
            LEX_IDLE: begin
                if (!held_v) begin
                    begin_token(c);
                end else if (c == h) begin
                    put_res(pair_kind(h), h, 1'b1, 1'b1, 1'b0);
                    put_res(pair_kind(h), c, 1'b1, 1'b0, 1'b1);
                    clear_lex();
                end else if (h == CH_AMP) begin
                    // lone ampersand becomes the head of a word
                    lex_mode = LEX_WORD;
                    tok_open = 1'b0;
                    word_advance(c);
                end else begin
                    put_res(op_kind(h), h, 1'b1, 1'b1, 1'b1);
                    begin_token(c);
                end
            end
            LEX_WORD: word_advance(c);
            LEX_QUOTED: begin
                if (c == closing) begin
                    if (held_v)
                        put_tok_char(quote_kind(), h, 1'b1);
                    else if (!tok_open)
                        put_res(quote_kind(), '0, 1'b0, 1'b1, 1'b1);
                    clear_lex();
                end else begin
                    if (held_v)
                        put_tok_char(quote_kind(), h, 1'b0);
                    held_chr = c;
                    held_v   = 1'b1;
                end
            end
            default: begin
                if (c == CH_AMP) begin
                    put_tok_char(KIND_WORD, h, 1'b1);
                    put_res(KIND_AND, CH_AMP, 1'b1, 1'b1, 1'b0);
                    put_res(KIND_AND, CH_AMP, 1'b1, 1'b0, 1'b1);
                    clear_lex();
                end else begin
                    put_tok_char(KIND_WORD, h, 1'b0);
                    lex_mode = LEX_WORD;
                    held_chr = CH_AMP;
                    word_advance(c);
                end
            end
        endcase
    endtask

    // Close whatever is open at the end of the line.
    task automatic flush_line();
        logic [CHAR_W-1:0] h;
        h = held_chr;
        case (lex_mode)
            LEX_IDLE: begin
                if (held_v) begin
                    if (h == CH_AMP)
                        put_res(KIND_WORD, h, 1'b1, 1'b1, 1'b1);
                    else
                        put_res(op_kind(h), h, 1'b1, 1'b1, 1'b1);
                end
            end
            LEX_WORD: put_tok_char(KIND_WORD, h, 1'b1);
            LEX_QUOTED: begin
                if (held_v)
                    put_tok_char(quote_kind(), h, 1'b1);
                else if (!tok_open)
                    put_res(quote_kind(), '0, 1'b0, 1'b1, 1'b1);
            end
            default: begin
                put_tok_char(KIND_WORD, h, 1'b0);
                put_tok_char(KIND_WORD, CH_AMP, 1'b1);
            end
        endcase
        clear_lex();
    endtask

    task automatic predict_tokens(input logic [CHAR_W-1:0] c, input logic eol);
        step_q.delete();
        take_char(c);
        if (eol) begin
            flush_line();
            if (step_q.size() == 0)
                put_res(KIND_WORD, '0, 1'b0, 1'b0, 1'b0);
            step_q[step_q.size()-1].done = 1'b1;
        end
        foreach (step_q[i])
            tok_q.push_back(step_q[i]);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_lex();
            tok_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                predict_tokens(i_s_tdata[CHAR_W-1:0], i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                got_res = '{kind:  i_m_tuser,
                            chr:   i_m_tdata[CHAR_W-1:0],
                            chr_v: i_m_tdata[CHAR_W],
                            first: i_m_tdata[CHAR_W+1],
                            last:  i_m_tdata[CHAR_W+2],
                            done:  i_m_tlast};
                if (tok_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("token word %0d: none expected, got kind %0d byte %02h tdata %04h",
                                 word_idx, got_res.kind, got_res.chr, i_m_tdata);
                end else begin
                    want_res = tok_q.pop_front();
                    if (got_res !== want_res || i_m_tdata[M_TDATA_W-1:CHAR_W+3] !== '0) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $write("token word %0d: expected kind %0d byte %02h v%b f%b l%b d%b,",
                                   word_idx, want_res.kind, want_res.chr, want_res.chr_v,
                                   want_res.first, want_res.last, want_res.done);
                            $display(" got kind %0d byte %02h v%b f%b l%b d%b pad %h",
                                     got_res.kind, got_res.chr, got_res.chr_v, got_res.first,
                                     got_res.last, got_res.done,
                                     i_m_tdata[M_TDATA_W-1:CHAR_W+3]);
                        end
                    end
                end
                word_idx++;
            end
        end
        o_pending  <= tok_q.size();
        o_fail_cnt <= fail_cnt;
    end

endmodule

// File: dv/tb.sv
// Testbench top for shell_command_tokenizer_core: clock, reset, stimulus, verdict.
// Depends on sct_pkg and on sct_token_checker, which predicts and compares.
module tb;
    import sct_pkg::*;

    localparam int ITEMS        = 180;  // characters to send over the whole run
    localparam int QUIET_TAIL   = 30;   // last characters sent with no idling at all
    localparam int STALL_LIMIT  = 500;  // cycles without any accepted word
    localparam int DRAIN_CYCLES = 10;

    typedef enum int {PC_WORD, PC_OP, PC_QUOTED, PC_AND, PC_SEP, PC_NOISE} t_piece;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;    // character[6:0], pad[7]
    logic                 s_tlast  = 1'b0;  // line_end
    logic                 s_tvalid = 1'b0;
    wire                  s_tready;
    wire  [M_TDATA_W-1:0] m_tdata;          // token_byte[6:0], byte_valid, first, last, pad
    wire  [KIND_W-1:0]    m_tuser;          // token_kind
    wire                  m_tlast;          // line_done
    wire                  m_tvalid;
    logic                 m_tready = 1'b0;

    int pending;
    int fail_cnt;
    int sent        = 0;
    int stall_left  = 0;
    int idle_cycles = 0;
    bit jitter_on   = 1'b1;

    logic [CHAR_W-1:0] line_q[$];
    logic [CHAR_W-1:0] op_chars[5] = '{CH_PIPE, CH_LT, CH_GT, CH_LPAREN, CH_RPAREN};

    always #10 i_clk = ~i_clk;

    shell_command_tokenizer_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tdata (s_tdata),
        .s_axis_tlast (s_tlast),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .m_axis_tdata (m_tdata),
        .m_axis_tuser (m_tuser),
        .m_axis_tlast (m_tlast),
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready)
    );

    sct_token_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (s_tdata),
        .i_s_tlast (s_tlast),
        .i_s_tvalid(s_tvalid),
        .i_s_tready(s_tready),
        .i_m_tdata (m_tdata),
        .i_m_tuser (m_tuser),
        .i_m_tlast (m_tlast),
        .i_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_pending (pending),
        .o_fail_cnt(fail_cnt)
    );

    // Receiver: while jitter is on, drop tready at random and keep it low until stall_left counts down to zero.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (jitter_on && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: end the run when no word moves on either port for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no word accepted for %0d cycles", STALL_LIMIT);
            $display("shell_command_tokenizer_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one character; hold tvalid high from word to word unless a gap is due.
    task automatic send_word(input logic [CHAR_W-1:0] ch, input logic eol);
        if (jitter_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_tdata  <= {1'b0, ch};
        s_tlast  <= eol;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_line(input string s);
        byte b;
        for (int i = 0; i < s.len(); i++) begin
            b = s[i];
            send_word(b[CHAR_W-1:0], i == s.len() - 1);
        end
    endtask

    // Hold the input side until every predicted token word has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Printable character that neither ends a word nor starts an operator.
    function automatic logic [CHAR_W-1:0] word_char();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom_range(33, 126));
        while (c == CH_PIPE || c == CH_LT || c == CH_GT || c == CH_LPAREN ||
               c == CH_RPAREN || c == CH_SQUOTE || c == CH_DQUOTE || c == CH_AMP);
        return c;
    endfunction

    // Build one command line: mostly well-formed tokens, sometimes raw noise.
    task automatic build_line();
        t_piece            pc;
        int                n;
        logic [CHAR_W-1:0] q;
        logic [CHAR_W-1:0] c;
        line_q.delete();
        if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) line_q.push_back(CHAR_W'($urandom_range(1, 127)));
            return;
        end
        repeat ($urandom_range(1, 4)) begin
            pc = t_piece'($urandom_range(PC_WORD, PC_NOISE));
            if ($urandom_range(0, 1) == 1)
                pc = PC_WORD;
            case (pc)
                PC_WORD: begin
                    n = $urandom_range(1, 5);
                    repeat (n) begin
                        line_q.push_back(word_char());
                        if ($urandom_range(0, 5) == 0)
                            line_q.push_back(CH_AMP);
                    end
                end
                PC_OP: begin
                    q = op_chars[$urandom_range(0, 4)];
                    line_q.push_back(q);
                    if ($urandom_range(0, 1) == 1)
                        line_q.push_back(q);
                end
                PC_QUOTED: begin
                    q = ($urandom_range(0, 1) == 1) ? CH_DQUOTE : CH_SQUOTE;
                    line_q.push_back(q);
                    n = $urandom_range(0, 4);
                    repeat (n) begin
                        do c = CHAR_W'($urandom_range(1, 127)); while (c == q);
                        line_q.push_back(c);
                    end
                    // leave some quotes open until the line ends
                    if ($urandom_range(0, 5) != 0)
                        line_q.push_back(q);
                end
                PC_AND: begin
                    line_q.push_back(CH_AMP);
                    line_q.push_back(CH_AMP);
                end
                PC_SEP: begin
                    n = $urandom_range(1, 2);
                    repeat (n) line_q.push_back(CHAR_W'($urandom_range(1, 32)));
                end
                default: line_q.push_back(CHAR_W'($urandom_range(1, 127)));
            endcase
            if ($urandom_range(0, 2) == 0)
                line_q.push_back(CH_SPACE);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines: every token kind, pairs, quotes, ampersand cases.
        send_line("a&&||");             // word before an and pair, then an or pair
        send_line("<<>>()");            // heredoc, append, open, close
        send_line("''\"q\"'");          // empty pair, quoted char, open quote at line end
        send_line("|<>&k&");            // single ops, then one word that starts and ends with &
        send_word(7'd1, 1'b0);          // lowest control character as a separator
        send_word(7'd127, 1'b1);        // highest character as a word
        send_word(CH_SPACE, 1'b1);      // line end with no token: marker only
        drain();

        // Random lines; before each line that starts midway, pause until the output side catches up.
        while (sent < ITEMS) begin
            if (sent >= ITEMS / 2 && sent < ITEMS / 2 + 16)
                drain();
            jitter_on = (sent < ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            build_line();
            foreach (line_q[i])
                send_word(line_q[i], i == line_q.size() - 1);
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending != 0)
            $display("%0d token words never arrived", pending);
        if (fail_cnt == 0 && pending == 0)
            $display("shell_command_tokenizer_core: match");
        else
            $display("shell_command_tokenizer_core: mismatch");
        $finish;
    end

endmodule
